>>> rtl/ssq_pkg.sv
// Shared types and constants of the stride scheduler queue.
`timescale 1ns / 1ps
package ssq_pkg;

  localparam int PASS_BASE = 1024;
  localparam int DIV_W = 11;
  localparam int DIV_STEPS = 11;
  localparam int DIV_CNT_W = 4;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PICK = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_FIN,
    S_SCAN,
    S_SCAN_END,
    S_DIV_INIT,
    S_DIV,
    S_FIN_PICK
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic scan_rd;
    logic div_init;
    logic div_step;
    logic fin_op;
    logic fin_pick;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic is_pick;
    logic found;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/stride_scheduler_queue_core.sv
// Top level of the stride scheduler queue.
`timescale 1ns / 1ps
// Stride scheduler over a table of TASKS entries held in one single-port RAM. After reset
// the block clears every entry of the table before it takes its first item; configuration
// writes of max_slice are taken at any time. Enqueue, dequeue and tick go through accept,
// table read, and write back with result once the output register is free. Pick scans every
// entry through the RAM port, one per cycle, then derives the pass 1024/priority in an
// 11-step restoring divider. Each item yields one result transfer, held in an output
// register while the next item is accepted.
module stride_scheduler_queue_core import ssq_pkg::*; #(
  parameter int TASKS = 64,
  parameter int STRIDE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [5:0]  in_task_id,
  input  logic [7:0]  in_slice_in,
  input  logic [31:0] in_priority_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_pick_valid,
  output logic [5:0]  out_picked_id,
  output logic [31:0] out_picked_stride,
  output logic        out_resched_due,
  output logic [7:0]  out_slice_left,
  output logic [6:0]  out_queued_count
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ssq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssq_dp #(.TASKS(TASKS), .STRIDE_BITS(STRIDE_BITS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_valid         (cfg_valid),
    .cfg_data          (cfg_data),
    .in_opcode         (in_opcode),
    .in_task_id        (in_task_id),
    .in_slice_in       (in_slice_in),
    .in_priority_in    (in_priority_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pick_valid    (out_pick_valid),
    .out_picked_id     (out_picked_id),
    .out_picked_stride (out_picked_stride),
    .out_resched_due   (out_resched_due),
    .out_slice_left    (out_slice_left),
    .out_queued_count  (out_queued_count)
  );

endmodule

>>> rtl/ssq_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module ssq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/ssq_ctrl.sv
// Controller state machine of the stride scheduler queue.
`timescale 1ns / 1ps
module ssq_ctrl import ssq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:    if (sts.cnt_last) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = S_RD;
      S_RD:       state_nxt = sts.is_pick ? S_SCAN : S_FIN;
      S_FIN:      if (sts.out_free) state_nxt = S_IDLE;
      S_SCAN:     if (sts.cnt_last) state_nxt = S_SCAN_END;
      S_SCAN_END: state_nxt = S_DIV_INIT;
      S_DIV_INIT: state_nxt = sts.found ? S_DIV : S_FIN_PICK;
      S_DIV:      if (sts.div_done) state_nxt = S_FIN_PICK;
      S_FIN_PICK: if (sts.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR:    cmd.clear_wr = 1'b1;
      S_IDLE:     cmd.accept = in_valid;
      S_FIN:      cmd.fin_op = sts.out_free;
      S_SCAN:     cmd.scan_rd = 1'b1;
      S_DIV_INIT: cmd.div_init = 1'b1;
      S_DIV:      cmd.div_step = !sts.div_done;
      S_FIN_PICK: cmd.fin_pick = sts.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

>>> rtl/ssq_dp.sv
// Datapath of the stride scheduler queue: task table, scan, pass divider and result register.
`timescale 1ns / 1ps
module ssq_dp import ssq_pkg::*; #(
  parameter int TASKS = 64,
  parameter int STRIDE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_data,
  input  logic [1:0]  in_opcode,
  input  logic [5:0]  in_task_id,
  input  logic [7:0]  in_slice_in,
  input  logic [31:0] in_priority_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_pick_valid,
  output logic [5:0]  out_picked_id,
  output logic [31:0] out_picked_stride,
  output logic        out_resched_due,
  output logic [7:0]  out_slice_left,
  output logic [6:0]  out_queued_count
);

  localparam int AW = $clog2(TASKS);
  localparam int CW = $clog2(TASKS + 1);
  localparam int EW = STRIDE_BITS + 32 + 8 + 1;

  logic [7:0]  max_slice_r;
  op_t         op_r;
  logic [5:0]  id_r;
  logic [7:0]  slice_r;
  logic [31:0] prio_r;
  logic [AW-1:0] cnt_r;
  logic [CW-1:0] count_r;

  logic          cmp_v_r;
  logic          found_r;
  logic [AW-1:0] cmp_idx_r;
  logic [AW-1:0] best_idx_r;
  logic [STRIDE_BITS-1:0] best_stride_r;
  logic [31:0]   best_prio_r;
  logic [7:0]    best_slice_r;

  logic [DIV_W-1:0] dvd_r, dsr_r, q_r;
  logic [DIV_W:0]   rem_r;
  logic [DIV_CNT_W-1:0] step_r;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic          rd_mark;
  logic [7:0]    rd_slice;
  logic [31:0]   rd_prio;
  logic [STRIDE_BITS-1:0] rd_stride, diff, new_stride;
  logic          id_ok;

  logic          op_we, op_inc, op_dec, op_resched;
  logic [7:0]    op_sleft, slice_n, tick_s;
  logic [31:0]   prio_n;
  logic [EW-1:0] op_wdata;
  logic [DIV_W:0] rem_sh;

  ssq_ram #(.WIDTH(EW), .DEPTH(TASKS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd_mark   = ram_rdata[0];
  assign rd_slice  = ram_rdata[8:1];
  assign rd_prio   = ram_rdata[40:9];
  assign rd_stride = ram_rdata[EW-1 -: STRIDE_BITS];
  assign id_ok     = (32'(id_r) < TASKS);
  assign diff      = rd_stride - best_stride_r;
  assign new_stride = best_stride_r + STRIDE_BITS'(q_r);
  assign rem_sh    = {rem_r[DIV_W-1:0], dvd_r[DIV_W-1]};

  always_comb begin
    op_we = 1'b0;
    op_inc = 1'b0;
    op_dec = 1'b0;
    op_resched = 1'b0;
    op_sleft = 8'd0;
    op_wdata = ram_rdata;
    slice_n = ((slice_r == 8'd0) || (slice_r > max_slice_r)) ? max_slice_r : slice_r;
    prio_n = (prio_r == 32'd0) ? 32'd1 : prio_r;
    tick_s = (rd_slice != 8'd0) ? rd_slice - 8'd1 : 8'd0;
    if (id_ok) begin
      case (op_r)
        OP_ENQ: begin
          if (!rd_mark) begin
            op_we = 1'b1;
            op_inc = 1'b1;
            op_wdata = {rd_stride, prio_n, slice_n, 1'b1};
            op_sleft = slice_n;
          end else begin
            op_sleft = rd_slice;
          end
        end
        OP_DEQ: begin
          if (rd_mark) begin
            op_we = 1'b1;
            op_dec = 1'b1;
            op_wdata = {rd_stride, rd_prio, rd_slice, 1'b0};
          end
        end
        OP_TICK: begin
          op_we = 1'b1;
          op_wdata = {rd_stride, rd_prio, tick_s, rd_mark};
          op_resched = (tick_s == 8'd0);
          op_sleft = tick_s;
        end
        default: op_we = 1'b0;
      endcase
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_addr = AW'(id_r);
    ram_wdata = op_wdata;
    if (cmd.clear_wr) begin
      ram_we = 1'b1;
      ram_addr = cnt_r;
      ram_wdata = '0;
    end else if (cmd.scan_rd) begin
      ram_addr = cnt_r;
    end else if (cmd.fin_pick) begin
      ram_we = found_r;
      ram_addr = best_idx_r;
      ram_wdata = {new_stride, best_prio_r, best_slice_r, 1'b1};
    end else if (cmd.fin_op) begin
      ram_we = op_we;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_slice_r <= 8'd5;
      cnt_r <= '0;
      count_r <= '0;
      cmp_v_r <= 1'b0;
      found_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_slice_r <= cfg_data;
      end
      if (cmd.accept) begin
        cnt_r <= '0;
        found_r <= 1'b0;
      end else if (cmd.clear_wr || cmd.scan_rd) begin
        cnt_r <= cnt_r + AW'(1);
      end
      cmp_v_r <= cmd.scan_rd;
      if (cmp_v_r && rd_mark && (!found_r || diff[STRIDE_BITS-1])) begin
        found_r <= 1'b1;
      end
      if (cmd.fin_op && op_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.fin_op && op_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.fin_op || cmd.fin_pick) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= op_t'(in_opcode);
      id_r <= in_task_id;
      slice_r <= in_slice_in;
      prio_r <= in_priority_in;
    end
    cmp_idx_r <= cnt_r;
    if (cmp_v_r && rd_mark && (!found_r || diff[STRIDE_BITS-1])) begin
      best_idx_r <= cmp_idx_r;
      best_stride_r <= rd_stride;
      best_prio_r <= rd_prio;
      best_slice_r <= rd_slice;
    end
    if (cmd.div_init) begin
      dvd_r <= DIV_W'(PASS_BASE);
      rem_r <= '0;
      q_r <= '0;
      step_r <= '0;
      if (best_prio_r == 32'd0) begin
        dsr_r <= DIV_W'(1);
      end else if (best_prio_r > 32'(PASS_BASE)) begin
        dsr_r <= DIV_W'(PASS_BASE);
      end else begin
        dsr_r <= best_prio_r[DIV_W-1:0];
      end
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      step_r <= step_r + DIV_CNT_W'(1);
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_r <= rem_sh - {1'b0, dsr_r};
        q_r <= {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r <= {q_r[DIV_W-2:0], 1'b0};
      end
    end
    if (cmd.fin_op) begin
      out_pick_valid <= 1'b0;
      out_picked_id <= 6'd0;
      out_picked_stride <= 32'd0;
      out_resched_due <= op_resched;
      out_slice_left <= op_sleft;
      out_queued_count <= 7'(op_inc ? count_r + CW'(1) : (op_dec ? count_r - CW'(1) : count_r));
    end else if (cmd.fin_pick) begin
      out_pick_valid <= found_r;
      out_picked_id <= found_r ? 6'(best_idx_r) : 6'd0;
      out_picked_stride <= found_r ? 32'(new_stride) : 32'd0;
      out_resched_due <= 1'b0;
      out_slice_left <= 8'd0;
      out_queued_count <= 7'(count_r);
    end
  end

  always_comb begin
    sts.cnt_last = (cnt_r == AW'(TASKS - 1));
    sts.is_pick = (op_r == OP_PICK);
    sts.found = found_r;
    sts.div_done = (step_r == DIV_CNT_W'(DIV_STEPS));
    sts.out_free = !out_valid || !out_stall;
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= TASKS) else $error("queued count beyond table size");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin_op || cmd.fin_pick) |-> (!out_valid || !out_stall))
    else $error("result overwrote a waiting transfer");
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_v_r |-> !ram_we) else $error("table written during scan");
`endif

endmodule
